// ===== design/wbps_pkg.sv =====
package wbps_pkg;

  // Field widths fixed by the register map and the payload
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned OFFSET_W    = 32;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned PAT_BYTES   = 16;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned MAX_PATTERN = 16;
  localparam int unsigned MIN_PATTERN = 4;

  // Register reset values
  localparam logic [PAT_BYTES-1:0] CARE_RESET = '1;
  localparam logic [LEN_W-1:0]     LEN_RESET  = LEN_W'(MIN_PATTERN);

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_PAT_LOW  = 3'd0,
    CFG_PAT_HIGH = 3'd1,
    CFG_CARE     = 3'd2,
    CFG_LENGTH   = 3'd3,
    CFG_BASE     = 3'd4
  } cfg_reg_e;

  // One result entry of the output queue
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } result_t;

endpackage

// ===== design/wbps_cell.sv =====
// One window position: holds a byte, hands it on, compares the byte it receives
module wbps_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  shift_i,
  input  logic                                  clear_i,
  input  logic [7:0]                            byte_i,
  input  logic [wbps_pkg::PAT_BYTES-1:0][7:0]   pattern_i,
  input  logic [wbps_pkg::PAT_BYTES-1:0]        care_i,
  input  logic [3:0]                            len_m1_i,
  output logic [7:0]                            byte_o,
  output logic                                  ok_o
);

  localparam logic [3:0] IdxC = 4'(IDX);

  logic [7:0] byte_q, byte_d;
  logic       active;
  logic [3:0] pat_idx;

  // Pattern byte that lines up with this position for the current length
  always_comb begin
    active  = (IdxC <= len_m1_i);
    pat_idx = len_m1_i - IdxC;
    ok_o    = !active || !care_i[pat_idx] || (byte_i == pattern_i[pat_idx]);
  end

  // Window byte, zeroed at region end
  always_comb begin
    byte_d = byte_q;
    if (shift_i) begin
      byte_d = clear_i ? 8'd0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== design/wbps_outq.sv =====
// Two-entry result queue between the compare stage and the output channel
module wbps_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wbps_pkg::result_t   push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wbps_pkg::result_t   out_data_o
);

  wbps_pkg::result_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/wildcard_byte_pattern_scanner.sv =====
// Wildcard byte pattern scanner.
// Input channel (in_valid_i / in_stall_o) carries one region byte per transaction
// plus a flag on the final byte. Output channel (out_valid_o / out_stall_i) carries
// one transaction per region: found with the address of the first match, or
// not found with address zero when the final byte arrives without a match.
// Configuration (cfg_valid_i / cfg_ready_o) writes pattern bytes, care mask,
// pattern length and region base; writes are always taken.
// Throughput: one byte per cycle while the result queue is not full. Each
// incoming byte walks a chain of MAX_PATTERN window cells, all of which compare
// in the same cycle. A result is written into the result queue when the byte
// that completes it is accepted, and the queue presents it on the output.
// A two-entry result queue decouples the sides: input bytes keep flowing while
// a result waits; in_stall_o rises only when both entries are occupied.
// Reset clears the window, the byte offset, the match flag and the queue, and
// loads the register reset values; the block accepts bytes right after reset.
module wildcard_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MAX_PATTERN
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wbps_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [wbps_pkg::DATA_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [wbps_pkg::ADDR_W-1:0]   match_address_o
);

  localparam logic [wbps_pkg::LEN_W-1:0] MaxLenC = wbps_pkg::LEN_W'(MAX_PATTERN);
  localparam logic [wbps_pkg::LEN_W-1:0] MinLenC = wbps_pkg::LEN_W'(wbps_pkg::MIN_PATTERN);

  // Configuration registers
  logic [wbps_pkg::PAT_BYTES-1:0][7:0] pattern_q;
  logic [wbps_pkg::PAT_BYTES-1:0]      care_q;
  logic [wbps_pkg::LEN_W-1:0]          length_q;
  logic [wbps_pkg::ADDR_W-1:0]         base_q;

  logic [wbps_pkg::OFFSET_W-1:0]       offset_q, offset_d;
  logic                                done_q, done_d;

  logic                                in_acc, full, hit, push;
  logic [wbps_pkg::LEN_W-1:0]          eff_len;
  logic [3:0]                          len_m1;
  logic                                enough;
  logic [MAX_PATTERN-1:0]              ok_vec;
  logic [7:0]                          chain [MAX_PATTERN+1];
  wbps_pkg::result_t                   res, out_res;

  assign cfg_ready_o = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      care_q    <= wbps_pkg::CARE_RESET;
      length_q  <= wbps_pkg::LEN_RESET;
      base_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (wbps_pkg::cfg_reg_e'(cfg_index_i))
        wbps_pkg::CFG_PAT_LOW:  pattern_q[7:0]  <= cfg_data_i;
        wbps_pkg::CFG_PAT_HIGH: pattern_q[15:8] <= cfg_data_i;
        wbps_pkg::CFG_CARE:     care_q   <= cfg_data_i[wbps_pkg::PAT_BYTES-1:0];
        wbps_pkg::CFG_LENGTH:   length_q <= cfg_data_i[wbps_pkg::LEN_W-1:0];
        wbps_pkg::CFG_BASE:     base_q   <= cfg_data_i[wbps_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, clamped to the supported range
  always_comb begin
    if (length_q < MinLenC) begin
      eff_len = MinLenC;
    end else if (length_q > MaxLenC) begin
      eff_len = MaxLenC;
    end else begin
      eff_len = length_q;
    end
    len_m1 = 4'(eff_len - wbps_pkg::LEN_W'(1));
  end

  assign in_stall_o = full;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Window cell chain; cell 0 sees the incoming byte
  assign chain[0] = data_byte_i;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    wbps_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (in_acc),
      .clear_i   (last_byte_i),
      .byte_i    (chain[g]),
      .pattern_i (pattern_q),
      .care_i    (care_q),
      .len_m1_i  (len_m1),
      .byte_o    (chain[g+1]),
      .ok_o      (ok_vec[g])
    );
  end

  // Match decision and result formation
  always_comb begin
    enough    = (offset_q >= wbps_pkg::OFFSET_W'(len_m1));
    hit       = !done_q && enough && (&ok_vec);
    res.found = hit;
    res.addr  = base_q + wbps_pkg::ADDR_W'(offset_q) - wbps_pkg::ADDR_W'(len_m1);
    if (!hit) begin
      res.addr = '0;
    end
    push = in_acc && (hit || (last_byte_i && !done_q));
  end

  // Offset counter and match flag
  always_comb begin
    offset_d = offset_q;
    done_d   = done_q;
    if (in_acc) begin
      if (last_byte_i) begin
        offset_d = '0;
        done_d   = 1'b0;
      end else begin
        if (offset_q != '1) begin
          offset_d = offset_q + wbps_pkg::OFFSET_W'(1);
        end
        done_d = done_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      done_q   <= 1'b0;
    end else begin
      offset_q <= offset_d;
      done_q   <= done_d;
    end
  end

  wbps_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign found_o         = out_res.found;
  assign match_address_o = out_res.addr;

endmodule

// ===== design/wbps_checker.sv =====
// Port-level checks on the scanner
module wbps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        found_o,
  input logic [wbps_pkg::ADDR_W-1:0] match_address_o
);

  // A not-found transaction always carries address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (match_address_o == '0))
    else $error("not-found result with nonzero address");

  // Input is only held off while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // No result appears without an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(in_valid_i && !in_stall_o)) |=> !out_valid_o)
    else $error("result appeared without an input transaction");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(found_o) && $stable(match_address_o)))
    else $error("stalled result changed");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .found_o         (found_o),
  .match_address_o (match_address_o)
);

// ===== verif/wildcard_byte_pattern_scanner_tb.sv =====
`timescale 1ns / 100ps

module wildcard_byte_pattern_scanner_tb;
  import wbps_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int IDLE_PCT     = 27;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_WAIT  = 3;
  localparam int DRAIN_CYCLES = 10;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 32;

  // Phases with fixed settings
  localparam int PH_WIDEST   = 0;
  localparam int PH_ALL_WILD = 1;
  localparam int PH_SHORTEST = 2;
  localparam int PH_MIN_LEN  = 3;
  localparam int PH_NO_IDLE  = 4;
  localparam int PH_PRESSURE = 6;

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  // Predicts the search outcome of each region and holds the pending outcomes
  class signature_tracker;
    logic [DATA_W-1:0]    pat_low;
    logic [DATA_W-1:0]    pat_high;
    logic [PAT_BYTES-1:0] care;
    logic [LEN_W-1:0]     plen;
    logic [ADDR_W-1:0]    base;
    logic [7:0]           win [PAT_BYTES];
    logic [OFFSET_W-1:0]  offset;
    bit                   done;
    result_t              expected_results [$];
    int unsigned          errors;

    function new();
      pat_low  = '0;
      pat_high = '0;
      care     = CARE_RESET;
      plen     = LEN_RESET;
      base     = '0;
      errors   = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (win[i]) win[i] = 8'h00;
      offset = '0;
      done   = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [DATA_W-1:0] v);
      case (idx)
        CFG_PAT_LOW:  pat_low  = v;
        CFG_PAT_HIGH: pat_high = v;
        CFG_CARE:     care     = v[PAT_BYTES-1:0];
        CFG_LENGTH:   plen     = v[LEN_W-1:0];
        CFG_BASE:     base     = v[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // Out-of-range lengths clamp to the supported span
    function int eff_len();
      if (plen < MIN_PATTERN) return MIN_PATTERN;
      if (plen > MAX_PATTERN) return MAX_PATTERN;
      return int'(plen);
    endfunction

    function logic [7:0] pattern_byte(int k);
      logic [2*DATA_W-1:0] all;
      all = {pat_high, pat_low};
      return all[8*k +: 8];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Accepted byte: shift window, compare at this offset, close region on last
    function void note_byte(logic [7:0] b, logic lst);
      int      len;
      bit      hit;
      result_t r;
      len = eff_len();
      for (int i = PAT_BYTES - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      if (!done && (64'(offset) + 1 >= 64'(len))) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (care[k] && win[len-1-k] != pattern_byte(k)) hit = 1'b0;
        end
        if (hit) begin
          r.found = 1'b1;
          r.addr  = base + ADDR_W'(offset) - ADDR_W'(len - 1);
          expected_results = {expected_results, r};
          done = 1'b1;
        end
      end
      if (offset != '1) offset++;
      if (lst) begin
        if (!done) begin
          r.found = 1'b0;
          r.addr  = '0;
          expected_results = {expected_results, r};
        end
        clear_region();
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic found, logic [ADDR_W-1:0] addr);
      result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result found=%0b addr=%h", found, addr));
      end else begin
        want = expected_results.pop_front();
        if (found !== want.found)
          report($sformatf("found got %0b want %0b", found, want.found));
        if (addr !== want.addr)
          report($sformatf("match_address got %h want %h", addr, want.addr));
      end
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [IDX_W-1:0]    cfg_index_i = '0;
  logic [DATA_W-1:0]   cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          data_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                found_o;
  logic [ADDR_W-1:0]   match_address_o;

  signature_tracker tracker = new();
  bit               no_idle   = 1'b0;
  int unsigned      hold_asks = 0;
  int unsigned      cycles    = 0;

  wildcard_byte_pattern_scanner dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Global watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("wildcard_byte_pattern_scanner verification failed");
      $finish;
    end
  end

  // Result side: check each transaction, random stall, long hold on request
  initial begin
    int unsigned hold_seen;
    int          hold_left;
    hold_seen = 0;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) tracker.check_result(found_o, match_address_o);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // One byte transaction; valid stays high afterwards until the next call
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_byte(b, lst);
  endtask

  task automatic send_seq(input logic [7:0] seq [$], input logic ends);
    foreach (seq[i]) send_byte(seq[i], ends && (i == seq.size() - 1));
  endtask

  // Random region, optionally with the pattern planted (and maybe damaged)
  task automatic send_region(input int n, input int plant_at, input int corrupt_at);
    logic [7:0] b;
    int         len;
    int         k;
    len = tracker.eff_len();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1)) b = tracker.pattern_byte($urandom_range(len - 1));
      else b = 8'($urandom);
      if (plant_at >= 0 && i >= plant_at && i < plant_at + len) begin
        k = i - plant_at;
        if (tracker.care[k]) b = tracker.pattern_byte(k);
        if (k == corrupt_at) b ^= 8'(1 << $urandom_range(7));
      end
      send_byte(b, i == n - 1);
    end
  endtask

  // Drop valid, wait for outstanding results, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [DATA_W-1:0] pl, input logic [DATA_W-1:0] ph,
                              input logic [DATA_W-1:0] cw, input logic [DATA_W-1:0] lw,
                              input logic [DATA_W-1:0] bw);
    cfg_reg_e          regs [5];
    logic [DATA_W-1:0] vals [5];
    regs = '{CFG_PAT_LOW, CFG_PAT_HIGH, CFG_CARE, CFG_LENGTH, CFG_BASE};
    vals = '{pl, ph, cw, lw, bw};
    foreach (regs[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.set_reg(regs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0] pl, ph, cw, lw, bw;
    logic [15:0]       care;
    int                len, n, at, bad, sent;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero pattern, match lands on the final byte
    send_seq({8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
    settle();

    // Length below range, base near the top so the address wraps
    pl = 64'h8877_6655_4433_2211;
    ph = 64'hFFEE_DDCC_BBAA_0099;
    program_regs(pl, ph, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFE3,
                 64'h0000_FFFF_FFFF_FFFE);
    // first match wraps to zero, repeat match ignored
    send_seq({8'hFF, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44,
              8'h11, 8'h22, 8'h33, 8'h44}, 1'b1);
    // region shorter than the pattern
    send_seq({8'h11, 8'h22, 8'h33}, 1'b1);
    // care mask changed mid-region applies to bytes already held
    send_seq({8'h11, 8'h22, 8'h33}, 1'b0);
    settle();
    program_regs(pl, ph, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0004,
                 64'h0000_FFFF_FFFF_FFFE);
    send_seq({8'h00}, 1'b1);
    settle();

    // Random phases, each with fresh settings
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      pl = {$urandom, $urandom};
      ph = {$urandom, $urandom};
      case ($urandom_range(3))
        0: care = '1;
        1: care = '0;
        2: care = 16'($urandom & $urandom);
        default: care = 16'($urandom);
      endcase
      len = $urandom_range(31);
      bw  = {$urandom, $urandom};
      case ($urandom_range(2))
        0: bw[ADDR_W-1:0] = '0;
        1: bw[ADDR_W-1:0] = ADDR_MAX;
        default: ;
      endcase
      case (phase)
        PH_WIDEST: begin
          len = MAX_PATTERN;
          care = '1;
          bw[ADDR_W-1:0] = ADDR_MAX;
        end
        PH_ALL_WILD: begin
          len = 31;
          care = '0;
          bw[ADDR_W-1:0] = '0;
        end
        PH_SHORTEST: len = 0;
        PH_MIN_LEN: begin
          len = MIN_PATTERN;
          care = '1;
        end
        default: ;
      endcase
      cw = {$urandom, $urandom};
      cw[PAT_BYTES-1:0] = care;
      lw = {$urandom, $urandom};
      lw[LEN_W-1:0] = LEN_W'(len);
      program_regs(pl, ph, cw, lw, bw);

      no_idle = (phase == PH_NO_IDLE);
      if (phase == PH_PRESSURE) hold_asks++;
      len  = tracker.eff_len();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (phase == PH_PRESSURE) n = $urandom_range(1, 3);
        else if ($urandom_range(99) < 70) n = $urandom_range(1, 24);
        else n = $urandom_range(25, 48);
        at  = -1;
        bad = -1;
        if (n >= len && $urandom_range(99) < 65) begin
          at = ($urandom_range(3) == 0) ? n - len : $urandom_range(n - len);
          if ($urandom_range(4) == 0) bad = $urandom_range(len - 1);
        end
        send_region(n, at, bad);
        sent += n;
      end
      settle();
    end

    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("wildcard_byte_pattern_scanner verification clean");
    end else begin
      $display("wildcard_byte_pattern_scanner verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/wbps_pkg.sv
design/wbps_cell.sv
design/wbps_outq.sv
design/wildcard_byte_pattern_scanner.sv
design/wbps_checker.sv
verif/wildcard_byte_pattern_scanner_tb.sv
